@@ src/swk_pkg.sv @@
// Constants, register indexes and the arctangent step table for the swerve wheel kinematics.
// No dependencies; used by swerve_drive_wheel_kinematics through scoped names.
package swk_pkg;

  localparam int ANGLE_COUNTS_DEF = 8191;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVER_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVER_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVER_C     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVER_D     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd5;

  localparam logic [15:0] RPM_GAIN_RST    = 16'd256;
  localparam logic [14:0] SPEED_LIMIT_RST = 15'd8000;

  localparam logic [23:0] QUARTER_TURN = 24'h400000;
  localparam logic [23:0] HALF_TURN    = 24'h800000;
  localparam logic [23:0] THREEQ_TURN  = 24'hC00000;

  localparam int NORM_BITS    = 41;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 15;
  localparam int CX_W         = 46;
  localparam int Z_W          = 26;

  // wheels whose lever terms enter with a minus sign (bit 0 is wheel A)
  localparam logic [3:0] C_NEG = 4'b1001;
  localparam logic [3:0] S_NEG = 4'b0011;

  localparam int BRK_DEG_A = 315;
  localparam int BRK_DEG_B = 225;
  localparam int BRK_DEG_C = 135;
  localparam int BRK_DEG_D = 45;

  function automatic logic [21:0] cordic_atan(input int unsigned i);
    case (i)
      0:  return 22'd2097152;
      1:  return 22'd1238021;
      2:  return 22'd654136;
      3:  return 22'd332050;
      4:  return 22'd166669;
      5:  return 22'd83416;
      6:  return 22'd41718;
      7:  return 22'd20860;
      8:  return 22'd10430;
      9:  return 22'd5215;
      10: return 22'd2608;
      11: return 22'd1304;
      12: return 22'd652;
      13: return 22'd326;
      14: return 22'd163;
      15: return 22'd81;
      default: return 22'd0;
    endcase
  endfunction

endpackage

@@ src/swerve_drive_wheel_kinematics.sv @@
// Four-wheel swerve inverse kinematics: chassis command in, steering angle and speed per wheel.
// Depends on swk_pkg for constants and the arctangent table.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one command word: vel_x, vel_y, yaw_rate.
//   Output channel (out_valid_o/out_ready_i) gives one word per command: four steering
//   angles, four limited speeds and the brake flag.
//   Configuration: write lever terms, rpm gain and speed limit with cfg_we_i while idle.
//   Throughput is one word per cycle while the receiver does not stall the output. The pipe
//   runs through the 32-step square root and the 15-step limit divider, with the 16-step
//   arctangent beside the square root, each step one register stage; the pipe stalls as a whole.
//   Reset empties the pipeline and loads register defaults (levers 0, gain 256,
//   limit 8000). When the receiver stalls, the output holds and all stages freeze;
//   in_ready_o drops only while a finished word waits and out_ready_i is low.
module swerve_drive_wheel_kinematics #(
  parameter int ANGLE_COUNTS = swk_pkg::ANGLE_COUNTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swk_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [15:0]             vel_x_i,
  input  logic signed [15:0]             vel_y_i,
  input  logic signed [15:0]             yaw_rate_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [12:0]                    angle_a_o,
  output logic [12:0]                    angle_b_o,
  output logic [12:0]                    angle_c_o,
  output logic [12:0]                    angle_d_o,
  output logic signed [15:0]             speed_a_o,
  output logic signed [15:0]             speed_b_o,
  output logic signed [15:0]             speed_c_o,
  output logic signed [15:0]             speed_d_o,
  output logic                           brake_o
);

  localparam int NW        = 4;
  localparam int CST       = swk_pkg::CORDIC_STEPS;
  localparam int SST       = swk_pkg::SQRT_STEPS;
  localparam int DST       = swk_pkg::DIV_STEPS;
  localparam int CXW       = swk_pkg::CX_W;
  localparam int ZW        = swk_pkg::Z_W;
  localparam int LAT_FRONT = 6;
  localparam int ANG_STAGE = LAT_FRONT + CST + 1;
  localparam int SPD_STAGE = LAT_FRONT + SST + 3 + DST;
  localparam int DLY_N     = SPD_STAGE - ANG_STAGE;
  localparam int LAT       = SPD_STAGE + 1;
  localparam int CNT_W     = $clog2(ANGLE_COUNTS + 1);
  localparam logic [CNT_W-1:0] CNT_V = CNT_W'(ANGLE_COUNTS);
  localparam logic [12:0] BRK_ANG [NW] = '{
    13'(ANGLE_COUNTS * swk_pkg::BRK_DEG_A / 360),
    13'(ANGLE_COUNTS * swk_pkg::BRK_DEG_B / 360),
    13'(ANGLE_COUNTS * swk_pkg::BRK_DEG_C / 360),
    13'(ANGLE_COUNTS * swk_pkg::BRK_DEG_D / 360)
  };

  function automatic logic [5:0] bit_len(input logic [30:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 31; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

  // configuration
  logic [31:0] lever_q [NW];
  logic [15:0] gain_q;
  logic [14:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NW; k++) lever_q[k] <= '0;
      gain_q  <= swk_pkg::RPM_GAIN_RST;
      limit_q <= swk_pkg::SPEED_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swk_pkg::REG_LEVER_A:     lever_q[0] <= cfg_wdata_i;
        swk_pkg::REG_LEVER_B:     lever_q[1] <= cfg_wdata_i;
        swk_pkg::REG_LEVER_C:     lever_q[2] <= cfg_wdata_i;
        swk_pkg::REG_LEVER_D:     lever_q[3] <= cfg_wdata_i;
        swk_pkg::REG_RPM_GAIN:    gain_q     <= cfg_wdata_i[15:0];
        swk_pkg::REG_SPEED_LIMIT: limit_q    <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // valid chain, whole pipe advances together
  logic [LAT-1:0] vld_q;
  logic           en;

  assign en          = ~vld_q[LAT-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // stage 1: capture
  logic signed [15:0] vx1_q, vy1_q, vw1_q;
  logic               brk1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx1_q  <= vel_x_i;
      vy1_q  <= vel_y_i;
      vw1_q  <= yaw_rate_i;
      brk1_q <= (vel_x_i == '0) && (vel_y_i == '0) && (yaw_rate_i == '0);
    end
  end

  // stage 2: lever products
  logic signed [31:0] pc2_q [NW];
  logic signed [31:0] ps2_q [NW];
  logic signed [15:0] vx2_q, vy2_q;
  logic               brk2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        pc2_q[k] <= vw1_q * $signed(lever_q[k][15:0]);
        ps2_q[k] <= vw1_q * $signed(lever_q[k][31:16]);
      end
      vx2_q  <= vx1_q;
      vy2_q  <= vy1_q;
      brk2_q <= brk1_q;
    end
  end

  // stage 3: wheel vectors
  logic signed [31:0] px3_q [NW];
  logic signed [31:0] py3_q [NW];
  logic               brk3_q;
  logic signed [31:0] vxs, vys;

  assign vxs = {{4{vx2_q[15]}}, vx2_q, 12'b0};
  assign vys = {{4{vy2_q[15]}}, vy2_q, 12'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        py3_q[k] <= swk_pkg::C_NEG[k] ? vys - pc2_q[k] : vys + pc2_q[k];
        px3_q[k] <= swk_pkg::S_NEG[k] ? vxs - ps2_q[k] : vxs + ps2_q[k];
      end
      brk3_q <= brk2_q;
    end
  end

  // stage 4: magnitudes, half-plane fold, axis cases
  logic [30:0]        ax4_q [NW];
  logic [30:0]        ay4_q [NW];
  logic signed [31:0] yn4_q [NW];
  logic               sp4_q [NW];
  logic [23:0]        phi4_q [NW];
  logic               brk4_q;
  logic               sp_d [NW];
  logic [23:0]        phi_d [NW];

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      sp_d[k]  = 1'b0;
      phi_d[k] = px3_q[k][31] ? swk_pkg::HALF_TURN : '0;
      if (py3_q[k] == '0) begin
        sp_d[k]  = 1'b1;
        phi_d[k] = px3_q[k][31] ? swk_pkg::HALF_TURN : '0;
      end else if (px3_q[k] == '0) begin
        sp_d[k]  = 1'b1;
        phi_d[k] = py3_q[k][31] ? swk_pkg::THREEQ_TURN : swk_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        ax4_q[k]  <= px3_q[k][31] ? 31'(-px3_q[k]) : px3_q[k][30:0];
        ay4_q[k]  <= py3_q[k][31] ? 31'(-py3_q[k]) : py3_q[k][30:0];
        yn4_q[k]  <= px3_q[k][31] ? -py3_q[k] : py3_q[k];
        sp4_q[k]  <= sp_d[k];
        phi4_q[k] <= phi_d[k];
      end
      brk4_q <= brk3_q;
    end
  end

  // stage 5: squares and normalizing shift count
  logic [61:0]        sqx5_q [NW];
  logic [61:0]        sqy5_q [NW];
  logic [30:0]        xn5_q [NW];
  logic signed [31:0] yn5_q [NW];
  logic [5:0]         sh5_q [NW];
  logic               sp5_q [NW];
  logic [23:0]        phi5_q [NW];
  logic               brk5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        sqx5_q[k] <= ax4_q[k] * ax4_q[k];
        sqy5_q[k] <= ay4_q[k] * ay4_q[k];
        xn5_q[k]  <= ax4_q[k];
        yn5_q[k]  <= yn4_q[k];
        sh5_q[k]  <= 6'(swk_pkg::NORM_BITS) - bit_len(ax4_q[k] | ay4_q[k]);
        sp5_q[k]  <= sp4_q[k];
        phi5_q[k] <= phi4_q[k];
      end
      brk5_q <= brk4_q;
    end
  end

  // stage 6 onward: arctangent and square root run side by side
  logic signed [CXW-1:0] cx_q [CST+1][NW];
  logic signed [CXW-1:0] cy_q [CST+1][NW];
  logic signed [ZW-1:0]  cz_q [CST+1][NW];
  logic                  csp_q [CST+1][NW];
  logic [23:0]           cphi_q [CST+1][NW];
  logic                  cbrk_q [CST+1];
  logic [63:0]           sv_q [SST+1][NW];
  logic [63:0]           sr_q [SST+1][NW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        cx_q[0][k]   <= $signed({15'b0, xn5_q[k]}) <<< sh5_q[k];
        cy_q[0][k]   <= CXW'(yn5_q[k]) <<< sh5_q[k];
        cz_q[0][k]   <= '0;
        csp_q[0][k]  <= sp5_q[k];
        cphi_q[0][k] <= phi5_q[k];
        sv_q[0][k]   <= 64'(sqx5_q[k]) + 64'(sqy5_q[k]);
        sr_q[0][k]   <= '0;
      end
      cbrk_q[0] <= brk5_q;
    end
  end

  for (genvar i = 0; i < CST; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN = $signed({4'b0, swk_pkg::cordic_atan(i)});
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < NW; k++) begin
          if (!cy_q[i][k][CXW-1]) begin
            cx_q[i+1][k] <= cx_q[i][k] + (cy_q[i][k] >>> i);
            cy_q[i+1][k] <= cy_q[i][k] - (cx_q[i][k] >>> i);
            cz_q[i+1][k] <= cz_q[i][k] + ATAN;
          end else begin
            cx_q[i+1][k] <= cx_q[i][k] - (cy_q[i][k] >>> i);
            cy_q[i+1][k] <= cy_q[i][k] + (cx_q[i][k] >>> i);
            cz_q[i+1][k] <= cz_q[i][k] - ATAN;
          end
          csp_q[i+1][k]  <= csp_q[i][k];
          cphi_q[i+1][k] <= cphi_q[i][k];
        end
        cbrk_q[i+1] <= cbrk_q[i];
      end
    end
  end

  for (genvar j = 0; j < SST; j++) begin : g_sqrt
    localparam logic [63:0] SBIT = 64'd1 << (62 - 2 * j);
    logic [63:0] st [NW];
    always_comb begin
      for (int k = 0; k < NW; k++) st[k] = sr_q[j][k] + SBIT;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < NW; k++) begin
          if (sv_q[j][k] >= st[k]) begin
            sv_q[j+1][k] <= sv_q[j][k] - st[k];
            sr_q[j+1][k] <= (sr_q[j][k] >> 1) + SBIT;
          end else begin
            sv_q[j+1][k] <= sv_q[j][k];
            sr_q[j+1][k] <= sr_q[j][k] >> 1;
          end
        end
      end
    end
  end

  // steering angle: rotate by a quarter turn and scale to encoder counts
  logic [23:0]            rel_d [NW];
  logic [24+CNT_W-1:0]    aprod_d [NW];
  logic [12:0]            ang_q [NW];
  logic                   abrk_q;

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      rel_d[k] = (csp_q[CST][k] ? cphi_q[CST][k] : cphi_q[CST][k] + cz_q[CST][k][23:0])
                 - swk_pkg::QUARTER_TURN;
      aprod_d[k] = rel_d[k] * CNT_V;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        ang_q[k] <= cbrk_q[CST] ? BRK_ANG[k] : 13'(aprod_d[k][24 +: CNT_W]);
      end
      abrk_q <= cbrk_q[CST];
    end
  end

  logic [12:0] dang_q [DLY_N][NW];
  logic        dbrk_q [DLY_N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dang_q[0] <= ang_q;
      dbrk_q[0] <= abrk_q;
      for (int n = 1; n < DLY_N; n++) begin
        dang_q[n] <= dang_q[n-1];
        dbrk_q[n] <= dbrk_q[n-1];
      end
    end
  end

  // speed: gain, largest, limit scaling
  logic [47:0] mp_d [NW];
  logic [19:0] mag1_q [NW];
  logic [19:0] mag2_q [NW];
  logic [19:0] lg_d;
  logic [19:0] lg2_q;
  logic        ov2_q;

  always_comb begin
    lg_d = '0;
    for (int k = 0; k < NW; k++) begin
      mp_d[k] = sr_q[SST][k][31:0] * gain_q;
      if (mag1_q[k] > lg_d) lg_d = mag1_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        mag1_q[k] <= mp_d[k][47:28];
        mag2_q[k] <= mag1_q[k];
      end
      lg2_q <= lg_d;
      ov2_q <= lg_d > {5'b0, limit_q};
    end
  end

  logic [34:0] dr_q [DST+1][NW];
  logic [14:0] dq_q [DST+1][NW];
  logic [14:0] dm_q [DST+1][NW];
  logic [19:0] dl_q [DST+1];
  logic        dov_q [DST+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        dr_q[0][k] <= mag2_q[k] * limit_q;
        dq_q[0][k] <= '0;
        dm_q[0][k] <= mag2_q[k][14:0];
      end
      dl_q[0]  <= lg2_q;
      dov_q[0] <= ov2_q;
    end
  end

  for (genvar t = 0; t < DST; t++) begin : g_div
    localparam int QB = DST - 1 - t;
    logic [34:0] dsh;
    assign dsh = 35'(dl_q[t]) << QB;
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < NW; k++) begin
          if (dr_q[t][k] >= dsh) begin
            dr_q[t+1][k] <= dr_q[t][k] - dsh;
            dq_q[t+1][k] <= dq_q[t][k] | (15'd1 << QB);
          end else begin
            dr_q[t+1][k] <= dr_q[t][k];
            dq_q[t+1][k] <= dq_q[t][k];
          end
          dm_q[t+1][k] <= dm_q[t][k];
        end
        dl_q[t+1]  <= dl_q[t];
        dov_q[t+1] <= dov_q[t];
      end
    end
  end

  // output register
  logic [12:0]        oang_q [NW];
  logic signed [15:0] ospd_q [NW];
  logic               obrk_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        oang_q[k] <= dang_q[DLY_N-1][k];
        ospd_q[k] <= 16'd0 - {1'b0, (dov_q[DST] ? dq_q[DST][k] : dm_q[DST][k])};
      end
      obrk_q <= dbrk_q[DLY_N-1];
    end
  end

  assign angle_a_o = oang_q[0];
  assign angle_b_o = oang_q[1];
  assign angle_c_o = oang_q[2];
  assign angle_d_o = oang_q[3];
  assign speed_a_o = ospd_q[0];
  assign speed_b_o = ospd_q[1];
  assign speed_c_o = ospd_q[2];
  assign speed_d_o = ospd_q[3];
  assign brake_o   = obrk_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during stall");

  a_brake_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brake_o |-> speed_a_o == '0 && speed_b_o == '0 &&
                               speed_c_o == '0 && speed_d_o == '0)
    else $error("nonzero speed in brake word");

  a_brake_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brake_o |-> angle_a_o == BRK_ANG[0] && angle_d_o == BRK_ANG[3])
    else $error("brake word without brake angles");

  a_speed_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (speed_a_o[15] || speed_a_o == '0) && (speed_b_o[15] || speed_b_o == '0)
                 && (speed_c_o[15] || speed_c_o == '0) && (speed_d_o[15] || speed_d_o == '0))
    else $error("positive wheel speed");

endmodule

@@ tb/swerve_drive_wheel_kinematics_test.sv @@
// Self-checking test of swerve_drive_wheel_kinematics: directed table, then random commands
// over several register settings and idling phases. Needs swk_pkg and the block's RTL.
`timescale 1ns / 100ps

module swerve_drive_wheel_kinematics_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 70;
  localparam logic [swk_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

  typedef struct {
    logic [12:0]        angle [4];
    logic signed [15:0] speed [4];
    logic               brake;
  } wheel_word_t;

  typedef struct {
    logic signed [15:0] vx, vy, vw;
    bit                 typed;
    logic [12:0]        ang;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [swk_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] vel_x_i = '0, vel_y_i = '0, yaw_rate_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [12:0] angle_a_o, angle_b_o, angle_c_o, angle_d_o;
  logic signed [15:0] speed_a_o, speed_b_o, speed_c_o, speed_d_o;
  logic brake_o;

  swerve_drive_wheel_kinematics u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [31:0] lever [4];
  logic [15:0] gain;
  logic [14:0] limit;
  wheel_word_t wheel_q [$];
  int errors = 0;
  int idle_mode = 0;
  int quiet = 0;

  function automatic bit idle_now(bit rx);
    if (idle_mode == 3) return $urandom_range(0, 99) < 20;
    if (idle_mode == 1 && !rx) return $urandom_range(0, 99) < 52;
    if (idle_mode == 2 && rx) return $urandom_range(0, 99) < 52;
    return 1'b0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] heading(longint x, longint y);
    longint z = 0, dx, dy;
    longint base = 0;
    if (y == 0) return (x < 0) ? swk_pkg::HALF_TURN : 24'd0;
    if (x == 0) return (y > 0) ? swk_pkg::QUARTER_TURN : swk_pkg::THREEQ_TURN;
    if (x < 0) begin
      x = -x;
      y = -y;
      base = swk_pkg::HALF_TURN;
    end
    while (x < (64'sd1 <<< 40) && ((y < 0) ? -y : y) < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < swk_pkg::CORDIC_STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy;
        y -= dx;
        z += longint'(swk_pkg::cordic_atan(i));
      end else begin
        x -= dy;
        y += dx;
        z -= longint'(swk_pkg::cordic_atan(i));
      end
    end
    return 24'(base + z);
  endfunction

  function automatic wheel_word_t wheel_targets(logic signed [15:0] vx, vy, vw);
    wheel_word_t w;
    longint px, py, c, s;
    longint unsigned m [4];
    longint unsigned top = 0, ax, ay;
    logic [23:0] rel;
    int brk [4] = '{swk_pkg::BRK_DEG_A, swk_pkg::BRK_DEG_B, swk_pkg::BRK_DEG_C,
                    swk_pkg::BRK_DEG_D};
    w.brake = (vx == 0 && vy == 0 && vw == 0);
    for (int k = 0; k < 4; k++) begin
      c = longint'($signed(lever[k][15:0]));
      s = longint'($signed(lever[k][31:16]));
      py = longint'(vy) * 4096 + (swk_pkg::C_NEG[k] ? -1 : 1) * longint'(vw) * c;
      px = longint'(vx) * 4096 + (swk_pkg::S_NEG[k] ? -1 : 1) * longint'(vw) * s;
      ax = (px < 0) ? -px : px;
      ay = (py < 0) ? -py : py;
      m[k] = (int_sqrt(ax * ax + ay * ay) * gain) >> 28;
      if (m[k] > top) top = m[k];
      if (w.brake) begin
        w.angle[k] = 13'(longint'(swk_pkg::ANGLE_COUNTS_DEF) * brk[k] / 360);
      end else begin
        rel = heading(px, py) - swk_pkg::QUARTER_TURN;
        w.angle[k] = 13'((longint'(rel) * swk_pkg::ANGLE_COUNTS_DEF) >> 24);
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (top > limit) m[k] = m[k] * limit / top;
      w.speed[k] = 16'(-m[k]);
    end
    return w;
  endfunction

  task automatic write_reg(logic [swk_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      swk_pkg::REG_LEVER_A: lever[0] = val;
      swk_pkg::REG_LEVER_B: lever[1] = val;
      swk_pkg::REG_LEVER_C: lever[2] = val;
      swk_pkg::REG_LEVER_D: lever[3] = val;
      swk_pkg::REG_RPM_GAIN: gain = val[15:0];
      swk_pkg::REG_SPEED_LIMIT: limit = val[14:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] la, lb, lc, ld, logic [31:0] g, l);
    write_reg(swk_pkg::REG_LEVER_A, la);
    write_reg(swk_pkg::REG_LEVER_B, lb);
    write_reg(swk_pkg::REG_LEVER_C, lc);
    write_reg(swk_pkg::REG_LEVER_D, ld);
    write_reg(swk_pkg::REG_RPM_GAIN, g);
    write_reg(swk_pkg::REG_SPEED_LIMIT, l);
    write_reg(REG_UNUSED, $urandom);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_cmd(logic signed [15:0] vx, vy, vw, bit typed = 0,
                          wheel_word_t typed_word = '{default: '0});
    while (idle_now(0)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vel_x_i <= vx;
    vel_y_i <= vy;
    yaw_rate_i <= vw;
    do @(posedge clk_i); while (!in_ready_o);
    wheel_q.push_back(typed ? typed_word : wheel_targets(vx, vy, vw));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 9))
      0: return 16'sh0000;
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3, 4: return 16'($signed($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_cmds(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) idle_mode = (i / 25) % 4;
      if ($urandom_range(0, 19) == 0) send_cmd(0, 0, 0);
      else send_cmd(rand_field(), rand_field(), rand_field());
    end
  endtask

  always @(posedge clk_i) out_ready_i <= !idle_now(1);

  always @(posedge clk_i) begin
    wheel_word_t e;
    logic [12:0] ga [4];
    logic signed [15:0] gs [4];
    ga = '{angle_a_o, angle_b_o, angle_c_o, angle_d_o};
    gs = '{speed_a_o, speed_b_o, speed_c_o, speed_d_o};
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (wheel_q.size() == 0) begin
        $error("word with no expectation");
        errors++;
      end else begin
        e = wheel_q.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (ga[k] !== e.angle[k]) begin
            $error("angle[%0d] expected %0d got %0d", k, e.angle[k], ga[k]);
            errors++;
          end
          if (gs[k] !== e.speed[k]) begin
            $error("speed[%0d] expected %0d got %0d", k, e.speed[k], gs[k]);
            errors++;
          end
        end
        if (brake_o !== e.brake) begin
          $error("brake expected %0d got %0d", e.brake, brake_o);
          errors++;
        end
      end
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cmd_row_t rows [$];
    wheel_word_t tw;
    lever = '{default: '0};
    gain = swk_pkg::RPM_GAIN_RST;
    limit = swk_pkg::SPEED_LIMIT_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: levers zero, so yaw alone gives a zero vector
    rows = '{
      '{0, 0, 0, 1, 0}, '{1, 0, 0, 1, 13'd6143}, '{0, 0, 16'sh7FFF, 1, 13'd6143},
      '{0, 0, 16'sh8000, 1, 13'd6143}, '{16'sh7FFF, 0, 0, 0, 0}, '{16'sh8000, 0, 0, 0, 0},
      '{0, 16'sh7FFF, 0, 0, 0}, '{0, 16'sh8000, 0, 0, 0},
      '{16'sh7FFF, 16'sh7FFF, 0, 0, 0}, '{16'sh8000, 16'sh7FFF, 0, 0, 0},
      '{-1, -1, 0, 0, 0}, '{16'sh0100, 16'sh0100, 16'sh0100, 0, 0}
    };
    foreach (rows[i]) begin
      tw = '{default: '0};
      tw.brake = (rows[i].vx == 0 && rows[i].vy == 0 && rows[i].vw == 0);
      if (tw.brake) begin
        tw.angle = '{13'd7167, 13'd5119, 13'd3071, 13'd1023};
      end else begin
        tw.angle = '{default: rows[i].ang};
      end
      send_cmd(rows[i].vx, rows[i].vy, rows[i].vw, rows[i].typed, tw);
    end
    drain();

    set_regs(32'h7FFF7FFF, 32'h80008000, 32'h7FFF8000, 32'h80007FFF, 32'hFFFF, 32'h7FFF);
    send_cmd(0, 0, 16'sh7FFF);
    send_cmd(0, 0, 16'sh8000);
    send_cmd(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
    send_cmd(0, 0, 0);
    random_cmds(100);
    drain();

    set_regs($urandom, $urandom, $urandom, $urandom, 32'd256, 32'd8000);
    random_cmds(110);
    drain();

    set_regs($urandom, $urandom, $urandom, $urandom, 32'hFFFF0000, $urandom);
    random_cmds(80);
    drain();

    set_regs($urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF8000);
    random_cmds(80);
    drain();

    set_regs(32'h10001000, 32'h1000F000, 32'hF000F000, 32'hF0001000, 32'h0400, 32'd3000);
    random_cmds(130);
    drain();

    set_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_cmds(130);
    drain();

    if (errors == 0 && wheel_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
